FILE: sv/fcss_pkg.sv
`default_nettype none
package fcss_pkg;

  // request kinds
  localparam logic REQ_BUS  = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // soft-switch addresses (even phase switches answer as idle)
  localparam logic [3:0] ADDR_PH0_ON    = 4'h1;
  localparam logic [3:0] ADDR_PH1_ON    = 4'h3;
  localparam logic [3:0] ADDR_PH2_ON    = 4'h5;
  localparam logic [3:0] ADDR_PH3_ON    = 4'h7;
  localparam logic [3:0] ADDR_MOTOR_OFF = 4'h8;
  localparam logic [3:0] ADDR_MOTOR_ON  = 4'h9;
  localparam logic [3:0] ADDR_SEL_0     = 4'hA;
  localparam logic [3:0] ADDR_SEL_1     = 4'hB;
  localparam logic [3:0] ADDR_Q6L       = 4'hC;
  localparam logic [3:0] ADDR_Q6H       = 4'hD;
  localparam logic [3:0] ADDR_Q7L       = 4'hE;
  localparam logic [3:0] ADDR_Q7H       = 4'hF;

  // constant answers
  localparam logic [7:0] STATUS_BYTE    = 8'hA0;
  localparam logic [7:0] HANDSHAKE_BYTE = 8'h80;
  localparam logic [7:0] IDLE_BYTE      = 8'hFF;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;

  localparam int TRACK_PORT_W = 6;

  // result of one item, before the image byte is merged in
  typedef struct packed {
    logic                    use_mem;
    logic [7:0]              data;
    logic                    motor;
    logic [TRACK_PORT_W-1:0] track;
  } fcss_result_t;

endpackage
`default_nettype wire

FILE: sv/fcss_image_ram.sv
`default_nettype none
module fcss_image_ram #(
  parameter int DEPTH = 232960,
  parameter int AW    = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write one image byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/fcss_switches.sv
`default_nettype none
module fcss_switches #(
  parameter int TRACKS      = 35,
  parameter int TRACK_BYTES = 6656,
  parameter int MAX_PHASE   = 70,
  parameter int AW          = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 req_type,
  input  wire logic [3:0]           reg_addr,
  input  wire logic [17:0]          image_addr,
  input  wire logic [7:0]           image_byte,
  output fcss_pkg::fcss_result_t    result,
  output logic                      mem_we,
  output logic      [AW-1:0]        mem_waddr,
  output logic      [7:0]           mem_wdata,
  output logic                      mem_re,
  output logic      [AW-1:0]        mem_raddr
);

  localparam int STORE = TRACKS * TRACK_BYTES;
  localparam int PW    = $clog2(MAX_PHASE + 1) < 1 ? 1 : $clog2(MAX_PHASE + 1);
  localparam int TW    = (PW > 1) ? PW - 1 : 1;
  localparam int BW    = $clog2(TRACK_BYTES + 1);
  localparam int CW    = (AW > 18) ? AW : 18;

  logic          motor_enable, motor_enable_next;
  logic [PW-1:0] head_phase, head_phase_next;
  logic [1:0]    last_phase_line, last_phase_line_next;
  logic [TW-1:0] track_index, track_index_next;
  logic [BW-1:0] byte_position, byte_position_next;
  logic          q6_latch, q6_latch_next;
  logic          q7_latch, q7_latch_next;
  logic          drive_select, drive_select_next;

  logic [1:0]    line;
  logic          fwd, back;
  logic [BW-1:0] pos_eff;
  logic          on_image;
  logic [CW-1:0] load_addr;

  assign line      = reg_addr[2:1];
  assign fwd       = (line == 2'(last_phase_line + 2'd1));
  assign back      = (line == 2'(last_phase_line + 2'd3));
  assign pos_eff   = (byte_position >= BW'(TRACK_BYTES)) ? '0 : byte_position;
  assign on_image  = (32'(track_index) < 32'(TRACKS));
  assign load_addr = CW'(image_addr);

  // decode the access and work out the next state
  always_comb begin
    motor_enable_next    = motor_enable;
    head_phase_next      = head_phase;
    last_phase_line_next = last_phase_line;
    track_index_next     = track_index;
    byte_position_next   = byte_position;
    q6_latch_next        = q6_latch;
    q7_latch_next        = q7_latch;
    drive_select_next    = drive_select;
    result.use_mem       = 1'b0;
    result.data          = fcss_pkg::ZERO_BYTE;
    mem_re               = 1'b0;
    mem_raddr            = AW'(AW'(track_index) * AW'(TRACK_BYTES) + AW'(pos_eff));
    mem_we               = 1'b0;
    mem_waddr            = load_addr[AW-1:0];
    mem_wdata            = image_byte;

    if (req_type == fcss_pkg::REQ_LOAD) begin
      mem_we = en && (load_addr < CW'(STORE));
    end else begin
      result.data = fcss_pkg::IDLE_BYTE;
      case (reg_addr)
        fcss_pkg::ADDR_PH0_ON, fcss_pkg::ADDR_PH1_ON,
        fcss_pkg::ADDR_PH2_ON, fcss_pkg::ADDR_PH3_ON: begin
          // step the head one half-track when the motor turns
          if (motor_enable) begin
            last_phase_line_next = line;
            if (fwd) begin
              head_phase_next = (head_phase < PW'(MAX_PHASE)) ?
                                PW'(head_phase + 1'b1) : PW'(MAX_PHASE);
            end else if (back) begin
              head_phase_next = (head_phase != '0) ? PW'(head_phase - 1'b1) : head_phase;
            end
            if (fwd || back) begin
              track_index_next = TW'(head_phase_next >> 1);
            end
          end
        end
        fcss_pkg::ADDR_MOTOR_OFF, fcss_pkg::ADDR_MOTOR_ON: begin
          motor_enable_next = reg_addr[0];
        end
        fcss_pkg::ADDR_SEL_0, fcss_pkg::ADDR_SEL_1: begin
          drive_select_next = reg_addr[0];
        end
        fcss_pkg::ADDR_Q6L: begin
          q6_latch_next = 1'b0;
          if (q7_latch) begin
            result.data = fcss_pkg::HANDSHAKE_BYTE;
          end else begin
            // fetch the next track byte and advance round the track
            byte_position_next = BW'(pos_eff + 1'b1);
            if (on_image) begin
              result.use_mem = 1'b1;
              mem_re         = en;
            end
          end
        end
        fcss_pkg::ADDR_Q6H: begin
          q6_latch_next = 1'b1;
          result.data   = fcss_pkg::ZERO_BYTE;
        end
        fcss_pkg::ADDR_Q7L, fcss_pkg::ADDR_Q7H: begin
          q7_latch_next = reg_addr[0];
          result.data   = fcss_pkg::STATUS_BYTE;
        end
        default: begin
          result.data = fcss_pkg::IDLE_BYTE;
        end
      endcase
    end
    result.motor = motor_enable_next;
    result.track = fcss_pkg::TRACK_PORT_W'(track_index_next);
  end

  // hold the switch state, advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_enable    <= 1'b0;
      head_phase      <= '0;
      last_phase_line <= '0;
      track_index     <= '0;
      byte_position   <= '0;
      q6_latch        <= 1'b0;
      q7_latch        <= 1'b0;
      drive_select    <= 1'b0;
    end else if (en) begin
      motor_enable    <= motor_enable_next;
      head_phase      <= head_phase_next;
      last_phase_line <= last_phase_line_next;
      track_index     <= track_index_next;
      byte_position   <= byte_position_next;
      q6_latch        <= q6_latch_next;
      q7_latch        <= q7_latch_next;
      drive_select    <= drive_select_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/floppy_controller_soft_switches_unit.sv
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | req_type, reg_addr, image_addr, image_byte
// out     | output    | out_valid/out_ready | read_data, motor_running, head_track
//
// One word is taken per cycle while in_ready is high; its result passes through
// the registered read of the image memory and then the output register.
// Reset (rst, synchronous) clears the switch state and both result stages;
// the image memory is not cleared and reads as loaded.
// With out_ready low, the memory stage keeps taking one further word, then
// in_ready drops until the output register is emptied.
module floppy_controller_soft_switches_unit #(
  parameter int TRACKS      = 35,
  parameter int TRACK_BYTES = 6656,
  parameter int MAX_PHASE   = 70
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [3:0]  reg_addr,
  input  wire logic [17:0] image_addr,
  input  wire logic [7:0]  image_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  read_data,
  output logic             motor_running,
  output logic      [fcss_pkg::TRACK_PORT_W-1:0] head_track
);

  localparam int STORE = TRACKS * TRACK_BYTES;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;

  logic                   accept;
  logic                   s1_valid;
  logic                   s1_adv;
  fcss_pkg::fcss_result_t res_comb;
  fcss_pkg::fcss_result_t s1_res;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata, mem_rdata;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  fcss_switches #(
    .TRACKS      (TRACKS),
    .TRACK_BYTES (TRACK_BYTES),
    .MAX_PHASE   (MAX_PHASE),
    .AW          (AW)
  ) u_switches (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .req_type   (req_type),
    .reg_addr   (reg_addr),
    .image_addr (image_addr),
    .image_byte (image_byte),
    .result     (res_comb),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  fcss_image_ram #(
    .DEPTH (STORE),
    .AW    (AW)
  ) u_image_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory stage: hold the word alongside the pending image read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res_comb;
    end
  end

  // output register: merge the image byte and hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data     <= s1_res.use_mem ? mem_rdata : s1_res.data;
      motor_running <= s1_res.motor;
      head_track    <= s1_res.track;
    end
  end

endmodule
`default_nettype wire

FILE: dv/floppy_controller_soft_switches_unit_tb.sv
module floppy_controller_soft_switches_unit_tb;
  import fcss_pkg::*;

  localparam int TRACKS         = 35;
  localparam int TRACK_BYTES    = 6656;
  localparam int MAX_PHASE      = 70;
  localparam int STORE_SIZE     = TRACKS * TRACK_BYTES;
  localparam int RANDOM_WORDS   = 940;
  localparam int TAIL_READS     = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  // phase-off switches answer as idle and change nothing
  localparam logic [3:0] ADDR_PH0_OFF = 4'h0;
  localparam logic [3:0] ADDR_PH1_OFF = 4'h2;
  localparam logic [3:0] ADDR_PH2_OFF = 4'h4;
  localparam logic [3:0] ADDR_PH3_OFF = 4'h6;

  localparam logic [3:0] PHASE_ON [4] = '{ADDR_PH0_ON, ADDR_PH1_ON, ADDR_PH2_ON, ADDR_PH3_ON};
  localparam logic [3:0] LATCH_OPS [8] = '{ADDR_Q6L, ADDR_Q6H, ADDR_Q7L, ADDR_Q7H,
                                           ADDR_SEL_0, ADDR_SEL_1, ADDR_MOTOR_OFF,
                                           ADDR_MOTOR_ON};

  typedef struct {
    logic [7:0] data;
    logic       motor;
    logic [5:0] track;
  } reply_t;

  // Shadow of the soft switches and the disk image; predicts each reply
  class soft_switch_book;
    bit         motor;
    bit   [6:0] phase;
    bit   [1:0] last_line;
    bit   [5:0] track;
    bit  [12:0] pos;
    bit         q6;
    bit         q7;
    bit         sel;
    bit   [7:0] image [int];
    reply_t     replies [$];
    int         mismatches;

    function void move_head(bit [1:0] line);
      bit [1:0] ahead;
      bit [1:0] behind;
      ahead  = last_line + 2'd1;
      behind = last_line + 2'd3;
      if (!motor) return;
      last_line = line;
      if (line == ahead) begin
        if (int'(phase) < MAX_PHASE) phase++;
      end else if (line == behind) begin
        if (phase != 0) phase--;
      end else begin
        return;
      end
      track = 6'(phase >> 1);
    endfunction

    function bit [7:0] next_track_byte();
      int         a;
      bit   [7:0] v;
      v = IDLE_BYTE;
      if (int'(pos) >= TRACK_BYTES) pos = '0;
      if (int'(track) < TRACKS) begin
        a = int'(track) * TRACK_BYTES + int'(pos);
        if (a < STORE_SIZE) v = image.exists(a) ? image[a] : ZERO_BYTE;
      end
      pos++;
      return v;
    endfunction

    // True when the next Q6L read would fetch an image byte never loaded
    function bit needs_fill(output int a);
      int p;
      p = (int'(pos) >= TRACK_BYTES) ? 0 : int'(pos);
      a = int'(track) * TRACK_BYTES + p;
      return !q7 && int'(track) < TRACKS && a < STORE_SIZE && !image.exists(a);
    endfunction

    function void take_word(logic rt, logic [3:0] ra, logic [17:0] ia, logic [7:0] ib);
      reply_t r;
      r.data = ZERO_BYTE;
      if (rt == REQ_LOAD) begin
        if (int'(ia) < STORE_SIZE) image[int'(ia)] = ib;
      end else begin
        r.data = IDLE_BYTE;
        case (ra)
          ADDR_PH0_ON, ADDR_PH1_ON, ADDR_PH2_ON, ADDR_PH3_ON: move_head(ra[2:1]);
          ADDR_MOTOR_OFF, ADDR_MOTOR_ON: motor = ra[0];
          ADDR_SEL_0, ADDR_SEL_1: sel = ra[0];
          ADDR_Q6L: begin
            q6 = 1'b0;
            r.data = q7 ? HANDSHAKE_BYTE : next_track_byte();
          end
          ADDR_Q6H: begin
            q6 = 1'b1;
            r.data = ZERO_BYTE;
          end
          ADDR_Q7L, ADDR_Q7H: begin
            q7 = ra[0];
            r.data = STATUS_BYTE;
          end
          default: r.data = IDLE_BYTE;
        endcase
      end
      r.motor = motor;
      r.track = track;
      replies.push_back(r);
    endfunction

    function void match_word(logic [7:0] d, logic m, logic [5:0] t);
      reply_t r;
      if (replies.size() == 0) begin
        $display("%0t: unexpected word read_data=%h motor_running=%b head_track=%0d",
                 $time, d, m, t);
        mismatches++;
        return;
      end
      r = replies.pop_front();
      if (d !== r.data) begin
        $display("%0t: read_data expected %h actual %h", $time, r.data, d);
        mismatches++;
      end
      if (m !== r.motor) begin
        $display("%0t: motor_running expected %b actual %b", $time, r.motor, m);
        mismatches++;
      end
      if (t !== r.track) begin
        $display("%0t: head_track expected %0d actual %0d", $time, r.track, t);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [3:0]  reg_addr;
  logic [17:0] image_addr;
  logic [7:0]  image_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic        motor_running;
  logic [5:0]  head_track;

  soft_switch_book book;
  int          issued;
  int          burst_left;
  bit          hold_due;
  int          quiet;

  floppy_controller_soft_switches_unit #(
    .TRACKS      (TRACKS),
    .TRACK_BYTES (TRACK_BYTES),
    .MAX_PHASE   (MAX_PHASE)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .reg_addr      (reg_addr),
    .image_addr    (image_addr),
    .image_byte    (image_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .motor_running (motor_running),
    .head_track    (head_track)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one word in bursts with random gaps; note it once accepted
  task automatic put_word(logic rt, logic [3:0] ra, logic [17:0] ia, logic [7:0] ib);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 120))
                                               : int'($urandom_range(1, 16));
      gap = int'($urandom_range(1, 8));
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid   <= 1'b1;
    req_type   <= rt;
    reg_addr   <= ra;
    image_addr <= ia;
    image_byte <= ib;
    do @(posedge clk); while (!in_ready);
    book.take_word(rt, ra, ia, ib);
    if (rt == REQ_BUS || int'(ia) < STORE_SIZE) issued++;
    @(negedge clk);
  endtask

  task automatic load(logic [17:0] ia, logic [7:0] ib);
    put_word(REQ_LOAD, 4'($urandom_range(0, 15)), ia, ib);
  endtask

  // Bus access; fill the image byte first if a track read would hit an unloaded one
  task automatic bus(logic [3:0] ra);
    int a;
    if (ra == ADDR_Q6L && book.needs_fill(a)) load(18'(a), 8'($urandom_range(0, 255)));
    put_word(REQ_BUS, ra, 18'($urandom_range(0, 262143)), 8'($urandom_range(0, 255)));
  endtask

  // Step the head through adjacent phase lines
  task automatic walk_head(int n, bit fwd, bit power);
    bit [1:0] nxt;
    if (power && !book.motor) bus(ADDR_MOTOR_ON);
    repeat (n) begin
      nxt = book.last_line + (fwd ? 2'd1 : 2'd3);
      bus(PHASE_ON[nxt]);
    end
  endtask

  // Receiver: stall pattern picked at random among four modes, plus one long hold-off
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 48 == 0) mode = int'($urandom_range(0, 3));
      if (hold_due) begin
        hold_due = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (cyc % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      book.match_word(read_data, motor_running, head_track);
  end

  // Watchdog: give up after a long stretch with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("floppy_controller_soft_switches_unit_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int  pick;
    bit  hold_sent;
    book       = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_BUS;
    reg_addr   = '0;
    image_addr = '0;
    image_byte = '0;
    hold_due   = 1'b0;
    hold_sent  = 1'b0;
    burst_left = 0;
    issued     = 0;
    quiet      = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed: image bounds, every switch, clamping and odd stepping
    load(18'd0, 8'h00);
    load(18'(STORE_SIZE - 1), 8'hFF);
    load(18'(STORE_SIZE), 8'h5A);
    load('1, 8'hA5);
    bus(ADDR_PH0_OFF);
    bus(ADDR_PH1_OFF);
    bus(ADDR_PH2_OFF);
    bus(ADDR_PH3_OFF);
    bus(ADDR_PH1_ON);
    bus(ADDR_MOTOR_ON);
    bus(ADDR_SEL_0);
    bus(ADDR_SEL_1);
    bus(ADDR_PH3_ON);
    bus(ADDR_PH0_ON);
    bus(ADDR_PH1_ON);
    bus(ADDR_PH3_ON);
    bus(ADDR_PH2_ON);
    bus(ADDR_Q6L);
    bus(ADDR_Q6H);
    bus(ADDR_Q7H);
    bus(ADDR_Q6L);
    bus(ADDR_Q7L);
    bus(ADDR_MOTOR_OFF);
    bus(ADDR_PH3_ON);

    // Random: head walks, track read bursts, loads, latch traffic and noise
    issued = 0;
    while (issued < RANDOM_WORDS) begin
      if (!hold_sent && issued >= RANDOM_WORDS / 3) begin
        hold_due  = 1'b1;
        hold_sent = 1'b1;
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 25) begin
        if ($urandom_range(0, 4) == 0) bus(PHASE_ON[book.last_line + 2'd2]);
        walk_head(int'($urandom_range(1, 12)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7) != 0);
      end else if (pick < 50) begin
        if (book.q7) bus(ADDR_Q7L);
        repeat ($urandom_range(1, 16)) bus(ADDR_Q6L);
      end else if (pick < 65) begin
        if ($urandom_range(0, 3) != 0)
          load(18'($urandom_range(0, STORE_SIZE - 1)), 8'($urandom_range(0, 255)));
        else
          load(18'($urandom_range(0, 262143)), 8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        bus(LATCH_OPS[$urandom_range(0, 7)]);
      end else begin
        bus(4'($urandom_range(0, 15)));
      end
    end

    // Park the head on the last half-track and read past the end of the image
    if (book.q7) bus(ADDR_Q7L);
    walk_head(MAX_PHASE + 2 - int'(book.phase), 1'b1, 1'b1);
    repeat (TAIL_READS) bus(ADDR_Q6L);
    walk_head(6, 1'b0, 1'b1);
    repeat (8) bus(ADDR_Q6L);

    // Drain outstanding replies, then let the pipeline settle
    in_valid <= 1'b0;
    while (book.replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0)
      $display("floppy_controller_soft_switches_unit_tb: clean");
    else
      $display("floppy_controller_soft_switches_unit_tb: errors");
    $finish;
  end

endmodule
